// File: design/positional_ordered_list_top_macros.svh
// Assertion macros for the positional ordered list.
`ifndef POSITIONAL_ORDERED_LIST_TOP_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define POL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define POL_ASSERT_NEVER(lbl, expr, msg) \
  `POL_ASSERT(lbl, !(expr), msg)
`else
`define POL_ASSERT(lbl, prop, msg)
`define POL_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// File: design/pol_pkg.sv
// Shared types and constants of the positional ordered list.
package pol_pkg;

  localparam int unsigned DEPTH_DEFAULT      = 16;
  localparam int unsigned DATA_WIDTH_DEFAULT = 32;
  localparam int unsigned OPCODE_W           = 3;
  localparam int unsigned STATUS_W           = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT_AT  = 3'd4,
    OP_DELETE_AT  = 3'd5,
    OP_DUMP       = 3'd6,
    OP_IGNORED    = 3'd7
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  typedef struct packed {
    logic ins;
    logic del;
    logic rot;
  } cell_cmd_t;

endpackage

// File: design/pol_cell.sv
// One storage cell of the list: holds a word and trades it with its neighbors.
module pol_cell
  import pol_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEFAULT,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int unsigned INDEX      = 0
) (
  input  logic                             clk_i,
  input  cell_cmd_t                        cmd_i,
  input  logic [$clog2(DEPTH+1)-1:0]       pos_i,
  input  logic [$clog2(DEPTH+1)-1:0]       cnt_i,
  input  logic [DATA_WIDTH-1:0]            new_data_i,
  input  logic [DATA_WIDTH-1:0]            left_i,
  input  logic [DATA_WIDTH-1:0]            right_i,
  input  logic [DATA_WIDTH-1:0]            head_i,
  output logic [DATA_WIDTH-1:0]            data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] Idx     = CntW'(INDEX);
  localparam logic [CntW-1:0] IdxNext = CntW'(INDEX + 1);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (Idx == pos_i) begin
        data_d = new_data_i;
      end else if (Idx > pos_i && Idx <= cnt_i) begin
        data_d = left_i;
      end
    end else if (cmd_i.del) begin
      if (Idx >= pos_i && IdxNext < cnt_i) begin
        data_d = right_i;
      end
    end else if (cmd_i.rot) begin
      if (IdxNext < cnt_i) begin
        data_d = right_i;
      end else if (IdxNext == cnt_i) begin
        data_d = head_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: design/pol_ctrl.sv
// Sequencer of the list: decodes requests, keeps the count and drives the result register.
module pol_ctrl
  import pol_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEFAULT,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic [OPCODE_W-1:0]           opcode_i,
  input  logic [$clog2(DEPTH+1)-1:0]    position_i,
  input  logic [DATA_WIDTH-1:0]         head_i,
  input  logic [DATA_WIDTH-1:0]         sel_data_i,
  output cell_cmd_t                     cmd_o,
  output logic [$clog2(DEPTH+1)-1:0]    eff_pos_o,
  output logic [$clog2(DEPTH+1)-1:0]    cnt_o,
  output logic                          dumping_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [STATUS_W-1:0]           status_o,
  output logic [DATA_WIDTH-1:0]         out_data_o,
  output logic [$clog2(DEPTH+1)-1:0]    entry_count_o,
  output logic                          last_result_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);
  localparam logic [CntW-1:0] One     = CntW'(1);

  state_e                state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic                  valid_q, valid_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  last_q, last_d;
  logic                  load;
  logic                  slot_free;
  logic                  fire;
  logic                  full;
  logic                  empty;
  opcode_e               op;

  assign op        = opcode_e'(opcode_i);
  assign slot_free = !valid_q || res_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && slot_free;
  assign fire      = req_valid_i && req_ready_o;
  assign full      = (cnt_q == FullCnt);
  assign empty     = (cnt_q == '0);

  always_comb begin
    unique case (op)
      OP_PUSH_FRONT, OP_POP_FRONT: eff_pos_o = '0;
      OP_PUSH_BACK:                eff_pos_o = cnt_q;
      OP_POP_BACK:                 eff_pos_o = cnt_q - One;
      default:                     eff_pos_o = position_i;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    cmd_o    = '0;
    load     = 1'b0;
    status_d = ST_OK;
    data_d   = '0;
    last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          load = 1'b1;
          unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                cmd_o.ins = 1'b1;
                cnt_d     = cnt_q + One;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                cmd_o.del = 1'b1;
                data_d    = sel_data_i;
                cnt_d     = cnt_q - One;
              end
            end
            OP_INSERT_AT: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (position_i > cnt_q) begin
                status_d = ST_RANGE;
              end else begin
                cmd_o.ins = 1'b1;
                cnt_d     = cnt_q + One;
              end
            end
            OP_DELETE_AT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (position_i >= cnt_q) begin
                status_d = ST_RANGE;
              end else begin
                cmd_o.del = 1'b1;
                data_d    = sel_data_i;
                cnt_d     = cnt_q - One;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                load    = 1'b0;
                state_d = S_DUMP;
                idx_d   = '0;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          load      = 1'b1;
          cmd_o.rot = 1'b1;
          data_d    = head_i;
          last_d    = (idx_q + One == cnt_q);
          idx_d     = idx_q + One;
          if (last_d) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    count_d = cnt_d;
    valid_d = load ? 1'b1 : (res_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      data_q   <= data_d;
      count_q  <= count_d;
      last_q   <= last_d;
    end
  end

  assign cnt_o         = cnt_q;
  assign dumping_o     = (state_q == S_DUMP);
  assign res_valid_o   = valid_q;
  assign status_o      = status_q;
  assign out_data_o    = data_q;
  assign entry_count_o = count_q;
  assign last_result_o = last_q;

endmodule

// File: design/positional_ordered_list_top.sv
// Top level of the positional ordered list: a row of cells under one sequencer.
// Every request but a dump gives one result, registered at acceptance and valid in the next cycle;
// such requests can be accepted every cycle while the result register drains.
// A dump gives one result per entry, one per cycle while results drain, rotating the
// cell row one step per result, and takes no request until its last result is loaded.
// Reset clears the count, the sequencer state and the result valid; cell words are
// unknown until written and are never read before that.
module positional_ordered_list_top
  import pol_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEFAULT,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT,
  localparam int unsigned CntW  = $clog2(DEPTH + 1),
  localparam int unsigned InW   = ((OPCODE_W + CntW + DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutW  = ((STATUS_W + DATA_WIDTH + CntW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // Fields from bit 0: opcode, position, entry_data, zero fill.
  input  logic [InW-1:0]  s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // Fields from bit 0: status, out_data, entry_count, zero fill.
  output logic [OutW-1:0] m_axis_tdata,
  output logic            m_axis_tlast
);

`include "positional_ordered_list_top_macros.svh"

  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [OPCODE_W-1:0]   opcode;
  logic [CntW-1:0]       position;
  logic [DATA_WIDTH-1:0] entry_data;
  cell_cmd_t             cmd;
  logic [CntW-1:0]       eff_pos;
  logic [CntW-1:0]       cnt;
  logic                  dumping;
  logic [DATA_WIDTH-1:0] sel_data;
  logic [STATUS_W-1:0]   status;
  logic [DATA_WIDTH-1:0] out_data;
  logic [CntW-1:0]       entry_count;
  logic                  s_fire;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  assign opcode     = s_axis_tdata[OPCODE_W-1:0];
  assign position   = s_axis_tdata[OPCODE_W +: CntW];
  assign entry_data = s_axis_tdata[OPCODE_W + CntW +: DATA_WIDTH];
  assign s_fire     = s_axis_tvalid && s_axis_tready;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_left
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_right
      assign right = cell_data[g+1];
    end
    pol_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (g)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .pos_i      (eff_pos),
      .cnt_i      (cnt),
      .new_data_i (entry_data),
      .left_i     (left),
      .right_i    (right),
      .head_i     (cell_data[0]),
      .data_o     (cell_data[g])
    );
  end

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (eff_pos == CntW'(i)) begin
        sel_data = sel_data | cell_data[i];
      end
    end
  end

  pol_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .opcode_i      (opcode),
    .position_i    (position),
    .head_i        (cell_data[0]),
    .sel_data_i    (sel_data),
    .cmd_o         (cmd),
    .eff_pos_o     (eff_pos),
    .cnt_o         (cnt),
    .dumping_o     (dumping),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .status_o      (status),
    .out_data_o    (out_data),
    .entry_count_o (entry_count),
    .last_result_o (m_axis_tlast)
  );

  assign m_axis_tdata = OutW'({entry_count, out_data, status});

  `POL_ASSERT_NEVER(a_no_accept_in_dump, dumping && s_axis_tready, "Request taken during a dump.")
  `POL_ASSERT_NEVER(a_count_bound, cnt > CntFull, "Count exceeds the capacity.")
  `POL_ASSERT(a_count_step, s_fire |=> (cnt == $past(cnt) || cnt == $past(cnt) + 1'b1 || cnt + 1'b1 == $past(cnt)), "Count moved by more than one.")
  `POL_ASSERT(a_dump_keeps_count, dumping |=> cnt == $past(cnt), "Count changed during a dump.")

endmodule

// File: test/tb_positional_ordered_list_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the positional ordered list with directed and random requests.
module tb_positional_ordered_list_top;
  import pol_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEFAULT;
  localparam int unsigned DATA_W      = DATA_WIDTH_DEFAULT;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned IN_W        = ((OPCODE_W + CNT_W + DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_W       = ((STATUS_W + DATA_W + CNT_W + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned TAIL_CYCLES = 24;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] word;
    logic [CNT_W-1:0]  count;
    logic              last;
  } list_result_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  logic [DATA_W-1:0] list_words[$];
  list_result_t      pending_results[$];

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int error_count = 0;
  int request_count = 0;
  int dump_count = 0;
  int result_count = 0;
  int full_hits = 0;
  int range_hits = 0;
  int empty_hits = 0;
  int cycle_count = 0;

  positional_ordered_list_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without finishing.", cycle_count);
      $display("FAIL positional_ordered_list_top");
      $finish;
    end
  end

  function automatic void queue_result(status_e status, logic [DATA_W-1:0] word, logic last);
    list_result_t r;
    r.status = status;
    r.word   = word;
    r.count  = CNT_W'(list_words.size());
    r.last   = last;
    pending_results.push_back(r);
    case (status)
      ST_FULL:  full_hits++;
      ST_RANGE: range_hits++;
      ST_EMPTY: empty_hits++;
      default: ;
    endcase
  endfunction

  function automatic void apply_list_request(opcode_e op, logic [CNT_W-1:0] pos,
                                             logic [DATA_W-1:0] word);
    logic [DATA_W-1:0] removed;
    int                n;
    n = list_words.size();
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (n >= DEPTH) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) list_words.push_front(word);
          else list_words.push_back(word);
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (n == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          removed = (op == OP_POP_FRONT) ? list_words.pop_front() : list_words.pop_back();
          queue_result(ST_OK, removed, 1'b1);
        end
      end
      OP_INSERT_AT: begin
        if (n >= DEPTH) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else if (pos > n) begin
          queue_result(ST_RANGE, '0, 1'b1);
        end else begin
          list_words.insert(pos, word);
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DELETE_AT: begin
        if (n == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else if (pos >= n) begin
          queue_result(ST_RANGE, '0, 1'b1);
        end else begin
          removed = list_words[pos];
          list_words.delete(pos);
          queue_result(ST_OK, removed, 1'b1);
        end
      end
      OP_DUMP: begin
        dump_count++;
        if (n == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) queue_result(ST_OK, list_words[i], i == n - 1);
        end
      end
      default: queue_result(ST_OK, '0, 1'b1);
    endcase
  endfunction

  task automatic send_request(input opcode_e op, input logic [CNT_W-1:0] pos,
                              input logic [DATA_W-1:0] word);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {word, pos, op};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_list_request(op, pos, word);
    request_count++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected, data %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] != want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   m_axis_tdata[1:0]);
        end
        if (m_axis_tdata[DATA_W+1:2] != want.word) begin
          error_count++;
          $display("%0t: out_data expected %h actual %h", $time, want.word,
                   m_axis_tdata[DATA_W+1:2]);
        end
        if (m_axis_tdata[DATA_W+CNT_W+1:DATA_W+2] != want.count) begin
          error_count++;
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   m_axis_tdata[DATA_W+CNT_W+1:DATA_W+2]);
        end
        if (m_axis_tlast != want.last) begin
          error_count++;
          $display("%0t: last_result expected %b actual %b", $time, want.last,
                   m_axis_tlast);
        end
      end
    end
  end

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic test_empty_list();
    send_request(OP_POP_FRONT, '0, '1);
    send_request(OP_POP_BACK, '0, '1);
    send_request(OP_DELETE_AT, '0, '1);
    send_request(OP_DUMP, '0, '0);
    send_request(OP_IGNORED, CNT_W'(DEPTH), '1);
  endtask

  task automatic test_fill_to_capacity();
    logic [DATA_W-1:0] word;
    send_request(OP_INSERT_AT, 5'd1, '1);
    send_request(OP_INSERT_AT, '0, '0);
    for (int i = 1; i < DEPTH; i++) begin
      case (i % 4)
        0:       word = '1;
        1:       word = {(DATA_W / 2){2'b10}};
        2:       word = {(DATA_W / 2){2'b01}};
        default: word = DATA_W'($urandom);
      endcase
      case (i % 3)
        0:       send_request(OP_PUSH_BACK, '0, word);
        1:       send_request(OP_PUSH_FRONT, '0, word);
        default: send_request(OP_INSERT_AT, CNT_W'($urandom_range(0, list_words.size())), word);
      endcase
    end
    send_request(OP_PUSH_FRONT, '0, '1);
    send_request(OP_PUSH_BACK, '0, '1);
    send_request(OP_INSERT_AT, '0, '1);
    send_request(OP_DUMP, '0, '0);
  endtask

  task automatic test_edge_positions();
    send_request(OP_DELETE_AT, CNT_W'(DEPTH), '0);
    send_request(OP_DELETE_AT, CNT_W'(DEPTH - 1), '0);
    send_request(OP_INSERT_AT, CNT_W'(DEPTH), '1);
    send_request(OP_INSERT_AT, CNT_W'(DEPTH - 1), '1);
    send_request(OP_DELETE_AT, '0, '0);
    send_request(OP_DUMP, '0, '0);
  endtask

  task automatic test_random_mix(input int total);
    opcode_e          op;
    logic [CNT_W-1:0] pos;
    int               roll;
    int               grow_pct;
    int               n;
    for (int k = 0; k < total; k++) begin
      if (k % 50 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (k == total / 2) wait_for_results();
      grow_pct = ((k / 40) % 2 == 0) ? 70 : 30;
      n = list_words.size();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        op = OP_DUMP;
      end else if (roll < 10) begin
        op = OP_IGNORED;
      end else if ($urandom_range(0, 99) < grow_pct) begin
        case ($urandom_range(0, 2))
          0:       op = OP_PUSH_FRONT;
          1:       op = OP_PUSH_BACK;
          default: op = OP_INSERT_AT;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_POP_FRONT;
          1:       op = OP_POP_BACK;
          default: op = OP_DELETE_AT;
        endcase
      end
      if ($urandom_range(0, 9) == 0) pos = CNT_W'($urandom_range(0, DEPTH));
      else if (op == OP_DELETE_AT) pos = CNT_W'(n > 0 ? $urandom_range(0, n - 1) : 0);
      else pos = CNT_W'($urandom_range(0, n));
      send_request(op, pos, random_word());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_fill_to_capacity();
    test_edge_positions();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_random_mix(420);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Sent %0d requests including %0d dumps and checked %0d results.",
             request_count, dump_count, result_count);
    $display("Status hits: %0d full, %0d empty, %0d out of range; %0d mismatches.",
             full_hits, empty_hits, range_hits, error_count);
    if (error_count == 0) begin
      $display("PASS positional_ordered_list_top");
    end else begin
      $display("FAIL positional_ordered_list_top");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/pol_pkg.sv
design/pol_cell.sv
design/pol_ctrl.sv
design/positional_ordered_list_top.sv
test/tb_positional_ordered_list_top.sv
